[rtl/hsav_pkg.sv]
package hsav_pkg;

  localparam int EXP_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MASS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE = 1'd1;

  localparam logic [23:0] MASS_RESET   = 24'd511;
  localparam logic [3:0]  CHARGE_RESET = 4'd1;

  localparam logic [31:0] AIR_X0      = 32'd1249280000;  // 305000 mm * 4096
  localparam logic [26:0] LOG_COEF    = 27'd113127690;   // 0.038*ln2, Q32
  localparam logic [19:0] HIGHLAND_SQ = 20'd722500;
  localparam logic [13:0] MOM_SCALE   = 14'd15625;       // GeV*4096 -> keV/64
  localparam logic [47:0] OUT_MAX     = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0]             m;
    logic signed [EXP_W-1:0] e;
  } pf_t;

  typedef struct packed {
    logic [4:0]  msb;
    logic [31:0] y;
  } lg_t;

  // Normalize to a 32-bit mantissa with its top bit set, truncating.
  function automatic pf_t pf_norm(input logic [63:0] v);
    pf_t         r;
    logic [5:0]  msb;
    logic [63:0] sh;
    msb = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) msb = 6'(i);
    end
    if (msb >= 6'd31) sh = v >> (msb - 6'd31);
    else sh = v << (6'd31 - msb);
    r.m = sh[31:0];
    if (v == '0) r.m = 32'h8000_0000;
    r.e = $signed({6'b0, msb}) - 12'sd31;
    return r;
  endfunction

  function automatic pf_t pf_mul(input pf_t a, input pf_t b);
    pf_t         r;
    logic [63:0] p;
    p = 64'(a.m) * 64'(b.m);
    if (p[63]) begin
      r.m = p[63:32];
      r.e = a.e + b.e + 12'sd32;
    end else begin
      r.m = p[62:31];
      r.e = a.e + b.e + 12'sd31;
    end
    return r;
  endfunction

  function automatic pf_t pf_add(input pf_t a, input pf_t b);
    pf_t                     r;
    pf_t                     hi;
    pf_t                     lo;
    logic signed [EXP_W-1:0] d;
    logic [31:0]             bs;
    logic [32:0]             s;
    if (a.e < b.e) begin
      hi = b;
      lo = a;
    end else begin
      hi = a;
      lo = b;
    end
    d  = hi.e - lo.e;
    bs = (d >= 12'sd32) ? 32'd0 : (lo.m >> d[4:0]);
    s  = {1'b0, hi.m} + {1'b0, bs};
    if (s[32]) begin
      r.m = s[32:1];
      r.e = hi.e + 12'sd1;
    end else begin
      r.m = s[31:0];
      r.e = hi.e;
    end
    return r;
  endfunction

  function automatic lg_t log_norm(input logic [31:0] n);
    lg_t r;
    r.msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (n[i]) r.msb = 5'(i);
    end
    r.y = n << (5'd31 - r.msb);
    return r;
  endfunction

  // One fraction bit of log2: square the Q31 mantissa, renormalize.
  function automatic logic [32:0] log_sq(input logic [31:0] y);
    logic [63:0] sq;
    logic [32:0] t;
    sq = 64'(y) * 64'(y);
    t  = sq[63:31];
    if (t[32]) return {1'b1, t[32:1]};
    return {1'b0, t[31:0]};
  endfunction

  function automatic logic [47:0] pf_to_out(input pf_t a);
    logic signed [EXP_W-1:0] ne;
    ne = -a.e;
    if (a.e >= 12'sd17) return OUT_MAX;
    if (a.e >= 12'sd0) return 48'(a.m) << a.e[4:0];
    if (a.e <= -12'sd32) return 48'd0;
    return 48'(a.m >> ne[4:0]);
  endfunction

endpackage

[rtl/hsav_in_if.sv]
interface hsav_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        momentum;
  logic signed [31:0] thickness;
  logic [31:0]        radiation_length;

  modport source(output valid, momentum, thickness, radiation_length, input ready);
  modport sink(input valid, momentum, thickness, radiation_length, output ready);
endinterface

[rtl/hsav_out_if.sv]
interface hsav_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] angle_variance;
  logic        computed;

  modport source(output valid, angle_variance, computed, input ready);
  modport sink(input valid, angle_variance, computed, output ready);
endinterface

[rtl/highland_scatter_angle_variance.sv]
// Highland multiple-scattering angle variance. Fully pipelined: one beat is
// accepted per cycle unless the result side stalls; each result passes through
// register stages 0..35. The depth is set by the two log2 units, sixteen
// 32x32 squaring stages each, and by the 33-bit restoring divider that retires
// three quotient bits per stage over eleven stages. Mass and charge are sampled
// as items pass, so write them only while the pipeline is empty. A stall on the
// result side freezes every stage; nothing is dropped or repeated.
module highland_scatter_angle_variance (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hsav_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hsav_pkg::CFG_DATA_W-1:0] cfg_data,
  hsav_in_if.sink                        item_in,
  hsav_out_if.source                     result_out
);
  import hsav_pkg::*;

  localparam int LAST       = 35;
  localparam int DIV_STAGES = 11;
  localparam int DIV_STEPS  = 3;

  logic [23:0]       mass;
  logic signed [3:0] charge;
  logic signed [7:0] csq;
  logic [LAST:0]     vld;
  logic              adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass   <= MASS_RESET;
      charge <= CHARGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASS:   mass <= cfg_data;
        REG_CHARGE: charge <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign csq = charge * charge;

  assign adv           = !vld[LAST] || result_out.ready;
  assign item_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAST-1:0], item_in.valid};
  end

  // stage 0
  logic [31:0] t_abs;
  logic [31:0] p0, xa0, xr0;
  logic        zf [0:34];
  logic        qf [0:34];

  assign t_abs = item_in.thickness[31] ? (~item_in.thickness + 32'd1) : item_in.thickness;

  always_ff @(posedge clk) begin
    if (adv) begin
      p0    <= item_in.momentum;
      xa0   <= t_abs;
      xr0   <= (item_in.radiation_length == '0) ? AIR_X0 : item_in.radiation_length;
      zf[0] <= (mass == '0) || (item_in.momentum == '0) || (t_abs == '0);
      qf[0] <= (charge == '0);
      for (int i = 1; i < 35; i++) begin
        zf[i] <= zf[i-1];
        qf[i] <= qf[i-1];
      end
    end
  end

  // stage 1: raw products and log normalization
  logic [45:0] pqraw1;
  logic [59:0] mmraw1;
  logic [25:0] n0raw1;
  logic [31:0] xv1, x0v1;
  logic [4:0]  lxm [1:17];
  logic [31:0] lxy [1:17];
  logic [15:0] lxf [1:17];
  logic [4:0]  l0m [1:17];
  logic [31:0] l0y [1:17];
  logic [15:0] l0f [1:17];
  lg_t         nx, n0;

  assign nx = log_norm(xa0);
  assign n0 = log_norm(xr0);

  always_ff @(posedge clk) begin
    if (adv) begin
      pqraw1 <= 46'(p0) * 46'(MOM_SCALE);
      mmraw1 <= {48'(mass) * 48'(mass), 12'b0};
      n0raw1 <= 26'(HIGHLAND_SQ) * 26'(csq[6:0]);
      xv1    <= xa0;
      x0v1   <= xr0;
      lxm[1] <= nx.msb;
      lxy[1] <= nx.y;
      lxf[1] <= '0;
      l0m[1] <= n0.msb;
      l0y[1] <= n0.y;
      l0f[1] <= '0;
    end
  end

  // stages 2..17: one fraction bit per stage for both logs
  for (genvar k = 2; k <= 17; k++) begin : g_log
    logic [32:0] sx, s0;
    assign sx = log_sq(lxy[k-1]);
    assign s0 = log_sq(l0y[k-1]);
    always_ff @(posedge clk) begin
      if (adv) begin
        lxm[k] <= lxm[k-1];
        lxy[k] <= sx[31:0];
        lxf[k] <= {lxf[k-1][14:0], sx[32]};
        l0m[k] <= l0m[k-1];
        l0y[k] <= s0[31:0];
        l0f[k] <= {l0f[k-1][14:0], s0[32]};
      end
    end
  end

  // stages 2..5: momentum terms, first numerator product and denominator
  pf_t pqf2, mmf2, xf2, x0f2, n0f2;
  pf_t pqsq3, x0f3, mmf3;
  pf_t den1_4, pqsq4, den5;
  pf_t num1_d [3:20];
  pf_t s_d    [4:22];
  pf_t den_d  [5:23];

  always_comb begin
    den5   = pf_mul(den1_4, pqsq4);
    den5.e = den5.e + 12'sd4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pqf2      <= pf_norm(64'(pqraw1));
      mmf2      <= pf_norm(64'(mmraw1));
      xf2       <= pf_norm(64'(xv1));
      x0f2      <= pf_norm(64'(x0v1));
      n0f2      <= pf_norm(64'(n0raw1));
      pqsq3     <= pf_mul(pqf2, pqf2);
      num1_d[3] <= pf_mul(n0f2, xf2);
      x0f3      <= x0f2;
      mmf3      <= mmf2;
      s_d[4]    <= pf_add(pqsq3, mmf3);
      den1_4    <= pf_mul(x0f3, pqsq3);
      pqsq4     <= pqsq3;
      den_d[5]  <= den5;
      for (int i = 4; i <= 20; i++) num1_d[i] <= num1_d[i-1];
      for (int i = 5; i <= 22; i++) s_d[i] <= s_d[i-1];
      for (int i = 6; i <= 23; i++) den_d[i] <= den_d[i-1];
    end
  end

  // stages 18..23: log factor and numerator
  logic signed [22:0] lval;
  logic               lneg18;
  logic [21:0]        lmag18;
  logic [48:0]        dprod;
  logic [30:0]        dval;
  logic [31:0]        fnext, f19;
  pf_t                ff20, ff21, num2_21, num3_22, num4_23;

  assign lval = $signed({2'b0, lxm[17], lxf[17]}) - $signed({2'b0, l0m[17], l0f[17]})
              - 23'sd262144;
  assign dprod = 49'(LOG_COEF) * 49'(lmag18);
  assign dval  = dprod[48:18];

  always_comb begin
    if (!lneg18) fnext = 32'h4000_0000 + 32'(dval);
    else if (dval >= 31'h4000_0000) fnext = 32'd1;
    else fnext = 32'h4000_0000 - 32'(dval);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lneg18  <= lval[22];
      lmag18  <= lval[22] ? 22'(-lval) : 22'(lval);
      f19     <= fnext;
      ff20    <= pf_norm(64'(f19));
      num2_21 <= pf_mul(num1_d[20], ff20);
      ff21    <= ff20;
      num3_22 <= pf_mul(num2_21, ff21);
      num4_23 <= pf_mul(num3_22, s_d[22]);
    end
  end

  // stages 24..34: restoring divide of the mantissas
  logic [32:0]             dw [0:DIV_STAGES-1];
  logic [32:0]             dq [0:DIV_STAGES-1];
  logic [31:0]             db [0:DIV_STAGES-1];
  logic signed [EXP_W-1:0] de [0:DIV_STAGES-1];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [32:0]             w_in, q_in, w_out, q_out, rem;
    logic [31:0]             b_in;
    logic signed [EXP_W-1:0] e_in;
    logic                    qb;
    if (j == 0) begin : g_first
      assign w_in = {1'b0, num4_23.m};
      assign q_in = '0;
      assign b_in = den_d[23].m;
      assign e_in = num4_23.e - den_d[23].e - 12'sd32;
    end else begin : g_next
      assign w_in = dw[j-1];
      assign q_in = dq[j-1];
      assign b_in = db[j-1];
      assign e_in = de[j-1];
    end
    always_comb begin
      w_out = w_in;
      q_out = q_in;
      rem   = '0;
      qb    = 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        qb  = (w_out >= {1'b0, b_in});
        rem = qb ? (w_out - {1'b0, b_in}) : w_out;
        w_out = {rem[31:0], 1'b0};
        q_out = {q_out[31:0], qb};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dw[j] <= w_out;
        dq[j] <= q_out;
        db[j] <= b_in;
        de[j] <= e_in;
      end
    end
  end

  // stage 35: output register
  pf_t         quo;
  logic [47:0] av35;
  logic        cp35;

  always_comb begin
    if (dq[DIV_STAGES-1][32]) begin
      quo.m = dq[DIV_STAGES-1][32:1];
      quo.e = de[DIV_STAGES-1] + 12'sd1;
    end else begin
      quo.m = dq[DIV_STAGES-1][31:0];
      quo.e = de[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zf[34]) begin
        av35 <= '0;
        cp35 <= 1'b0;
      end else if (qf[34]) begin
        av35 <= '0;
        cp35 <= 1'b1;
      end else begin
        av35 <= pf_to_out(quo);
        cp35 <= 1'b1;
      end
    end
  end

  assign result_out.valid          = vld[LAST];
  assign result_out.angle_variance = av35;
  assign result_out.computed       = cp35;

endmodule
